FILE: rtl/core/trt_pkg.sv
// ============================================================================
// trt_pkg: shared types and codes of the ternary rule table
// Request and response items, operation codes and status codes.
// ============================================================================
`default_nettype none

package trt_pkg;

    // Operation codes of a request item.
    typedef logic [1:0] t_op;
    localparam t_op OP_LOOKUP = 2'd0;
    localparam t_op OP_ADD    = 2'd1;
    localparam t_op OP_MODIFY = 2'd2;
    localparam t_op OP_DELETE = 2'd3;

    // Status codes of a response item.
    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_RANGE = 2'd2;

    // Action returned by a lookup that matches no entry.
    localparam logic [31:0] MISS_ACTION = 32'hFFFF_FFFF;

    // One request item.
    typedef struct packed {
        t_op         op;
        logic [5:0]  index;
        logic [63:0] key;
        logic [63:0] mask;
        logic [31:0] action;
        logic [63:0] digest_high;
        logic [63:0] digest_low;
    } t_req;

    // One response item.
    typedef struct packed {
        t_status     status;
        logic        hit;
        logic [5:0]  result_index;
        logic [31:0] result_action;
    } t_rsp;

endpackage

`default_nettype wire

FILE: rtl/core/trt_if.sv
// ============================================================================
// trt_if: valid/ready channels of the ternary rule table
// Request channel and response channel, each with source and sink views.
// ============================================================================
`default_nettype none

interface trt_req_if;
    import trt_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface trt_rsp_if;
    import trt_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/trt_entry_mem.sv
// ============================================================================
// trt_entry_mem: entry store of the rule table
// One write port and one read port; read data is registered.
// ============================================================================
`default_nettype none

module trt_entry_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 288,
    parameter int AW    = 5
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Synchronous write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Synchronous read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/trt_ctrl.sv
// ============================================================================
// trt_ctrl: sequencer of the ternary rule table
// Holds the valid bits, scans the entry store one entry per cycle for lookup
// and add, writes entries back, and registers the response item.
// ============================================================================
`default_nettype none

module trt_ctrl #(
    parameter int ENTRIES  = 32,
    parameter int KEY_BITS = 64,
    parameter int AW       = 5,
    parameter int MW       = 288
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    trt_req_if.sink            i_req,
    trt_rsp_if.source          o_rsp,
    output logic               o_we,
    output logic [AW-1:0]      o_waddr,
    output logic [MW-1:0]      o_wdata,
    output logic [AW-1:0]      o_raddr,
    input  wire logic [MW-1:0] i_rdata
);
    import trt_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    logic [1:0]         r_state, n_state;
    t_req               r_req, n_req;
    logic [AW-1:0]      r_cnt, n_cnt;
    logic               r_free_ok, n_free_ok;
    logic [AW-1:0]      r_free_idx, n_free_idx;
    logic [ENTRIES-1:0] r_valid, n_valid;
    t_status            r_status, n_status;
    logic               r_hit, n_hit;
    logic [5:0]         r_ridx, n_ridx;
    logic [31:0]        r_ract, n_ract;
    logic               r_out_valid, n_out_valid;
    t_rsp               r_out, n_out;

    logic                load;
    logic                in_idx_ok;
    logic [AW-1:0]       in_addr;
    logic [MW-1:0]       pack_in;
    logic [MW-1:0]       pack_reg;
    logic [KEY_BITS-1:0] e_key;
    logic [KEY_BITS-1:0] e_mask;
    logic [31:0]         e_act;
    logic [63:0]         e_dlo;
    logic [63:0]         e_dhi;
    logic                cur_valid;
    logic                key_match;
    logic                dig_match;
    logic                slot_ok;
    logic [AW-1:0]       slot;

    // Entry word layout: digest high, digest low, action, mask, key.
    assign pack_in  = {i_req.data.digest_high, i_req.data.digest_low, i_req.data.action,
                       i_req.data.mask[KEY_BITS-1:0], i_req.data.key[KEY_BITS-1:0]};
    assign pack_reg = {r_req.digest_high, r_req.digest_low, r_req.action,
                       r_req.mask[KEY_BITS-1:0], r_req.key[KEY_BITS-1:0]};

    assign e_key  = i_rdata[KEY_BITS-1:0];
    assign e_mask = i_rdata[2*KEY_BITS-1:KEY_BITS];
    assign e_act  = i_rdata[2*KEY_BITS+31:2*KEY_BITS];
    assign e_dlo  = i_rdata[2*KEY_BITS+95:2*KEY_BITS+32];
    assign e_dhi  = i_rdata[2*KEY_BITS+159:2*KEY_BITS+96];

    // Compare the entry read for the current scan position.
    assign cur_valid = r_valid[r_cnt];
    assign key_match = ((e_key ^ r_req.key[KEY_BITS-1:0]) & e_mask) == '0;
    assign dig_match = (e_dhi == r_req.digest_high) && (e_dlo == r_req.digest_low);

    assign in_idx_ok = {1'b0, i_req.data.index} < 7'(ENTRIES);
    assign in_addr   = i_req.data.index[AW-1:0];

    // A new free slot is taken from the scan if none was seen yet.
    assign slot_ok = r_free_ok || !cur_valid;
    assign slot    = r_free_ok ? r_free_idx : r_cnt;

    // Items are handled one at a time, so a write never overlaps a read of
    // the same entry within one item; no forwarding path is needed.
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_cnt       = r_cnt;
        n_free_ok   = r_free_ok;
        n_free_idx  = r_free_idx;
        n_valid     = r_valid;
        n_status    = r_status;
        n_hit       = r_hit;
        n_ridx      = r_ridx;
        n_ract      = r_ract;
        load        = 1'b0;
        o_we        = 1'b0;
        o_waddr     = slot;
        o_wdata     = pack_reg;
        o_raddr     = (r_cnt == LAST) ? '0 : r_cnt + AW'(1);

        unique case (r_state)
            S_IDLE: begin
                o_raddr = '0;
                if (i_req.valid) begin
                    n_req      = i_req.data;
                    n_cnt      = '0;
                    n_free_ok  = 1'b0;
                    n_free_idx = '0;
                    n_status   = ST_OK;
                    n_hit      = 1'b0;
                    n_ridx     = '0;
                    n_ract     = '0;
                    unique case (i_req.data.op) inside
                        OP_LOOKUP: begin
                            n_ract  = MISS_ACTION;
                            n_state = S_SCAN;
                        end
                        OP_ADD: begin
                            n_state = S_SCAN;
                        end
                        OP_MODIFY, OP_DELETE: begin
                            n_ridx  = i_req.data.index;
                            n_state = S_FINISH;
                            if (!in_idx_ok) begin
                                n_status = ST_RANGE;
                            end else if (i_req.data.op == OP_MODIFY) begin
                                o_we             = 1'b1;
                                o_waddr          = in_addr;
                                o_wdata          = pack_in;
                                n_valid[in_addr] = 1'b1;
                            end else begin
                                n_valid[in_addr] = 1'b0;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_cnt = r_cnt + AW'(1);
                if (r_req.op == OP_LOOKUP) begin
                    // First match in index order ends the scan.
                    if (cur_valid && key_match) begin
                        n_hit   = 1'b1;
                        n_ridx  = 6'(r_cnt);
                        n_ract  = e_act;
                        n_state = S_FINISH;
                    end else if (r_cnt == LAST) begin
                        n_state = S_FINISH;
                    end
                end else begin
                    // Add: look for the same digest, remember the lowest free slot.
                    if (cur_valid && dig_match) begin
                        n_hit   = 1'b1;
                        n_ridx  = 6'(r_cnt);
                        n_state = S_FINISH;
                    end else begin
                        if (!cur_valid && !r_free_ok) begin
                            n_free_ok  = 1'b1;
                            n_free_idx = r_cnt;
                        end
                        if (r_cnt == LAST) begin
                            n_state = S_FINISH;
                            if (slot_ok) begin
                                o_we          = 1'b1;
                                n_valid[slot] = 1'b1;
                                n_ridx        = 6'(slot);
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                    end
                end
            end
            S_FINISH: begin
                if (!r_out_valid || o_rsp.ready) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register of the response channel.
    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (load) begin
            n_out.status        = r_status;
            n_out.hit           = r_hit;
            n_out.result_index  = r_ridx;
            n_out.result_action = r_ract;
            n_out_valid         = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state with synchronous reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and scan registers.
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_cnt      <= n_cnt;
        r_free_ok  <= n_free_ok;
        r_free_idx <= n_free_idx;
        r_status   <= n_status;
        r_hit      <= n_hit;
        r_ridx     <= n_ridx;
        r_ract     <= n_ract;
        r_out      <= n_out;
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

`ifndef NO_ASSERTIONS
    // At most one entry becomes valid per cycle.
    a_one_new_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) <= $past($countones(r_valid)) + 1)
        else $error("more than one entry became valid in one cycle");

    // The scan position steps by one for every cycle the scan continues.
    a_scan_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && n_state == S_SCAN) |=> r_cnt == $past(r_cnt) + AW'(1))
        else $error("scan position skipped an entry");

    // A result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (!r_out_valid || o_rsp.ready))
        else $error("response item overwritten before it was taken");

    // An entry write always marks that entry valid.
    a_write_marks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |=> r_valid[$past(o_waddr)])
        else $error("entry written without becoming valid");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/ternary_rule_table.sv
// ============================================================================
// ternary_rule_table: first-match ternary flow table with add/modify/delete
// Scan: lookup and add run a scan from acceptance to the response item that
// reads one entry per cycle from the entry memory; modify and delete skip the
// scan and go straight to the response item.
// Throughput: one item at a time; the next item is accepted in the cycle after
// the response item is loaded into the output register.
// Reset: synchronous, active low; it clears every valid bit, so the table is
// empty at once and no clearing pass is run.
// ============================================================================
`default_nettype none

module ternary_rule_table #(
    parameter int ENTRIES  = 32,
    parameter int KEY_BITS = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    trt_req_if.sink   i_req,
    trt_rsp_if.source o_rsp
);
    import trt_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int MW = 2 * KEY_BITS + 160;

    logic          we;
    logic [AW-1:0] waddr;
    logic [MW-1:0] wdata;
    logic [AW-1:0] raddr;
    logic [MW-1:0] rdata;

    // Sequencer, valid bits and response register.
    trt_ctrl #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS),
        .AW       (AW),
        .MW       (MW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wdata (wdata),
        .o_raddr (raddr),
        .i_rdata (rdata)
    );

    // Entry store: key, mask, action and digest of every slot.
    trt_entry_mem #(
        .DEPTH (ENTRIES),
        .WIDTH (MW),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule

`default_nettype wire
